[src/r2fft_pkg.sv]
// Shared constants, types and functions for the radix-2 FFT block.
`timescale 1ns / 1ps
package r2fft_pkg;

    localparam int MAX_POINTS_DEF   = 1024;
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int TWIDDLE_BITS_DEF = 18;
    localparam int DATA_BITS        = 32;
    localparam int CFG_IDX_BITS     = 2;
    localparam int CFG_DATA_BITS    = 4;
    localparam int LOG_BITS         = 5;

    localparam logic [CFG_IDX_BITS-1:0] REG_LOG2_POINTS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_INVERSE     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SWAP_SIGN   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCALING     = 2'd3;

    localparam logic [1:0] SCALE_SQRT  = 2'd0;
    localparam logic [1:0] SCALE_ASYM  = 2'd2;

    localparam logic [DATA_BITS-1:0] ONE_Q30       = 32'd1073741824;
    localparam logic [DATA_BITS-1:0] INV_SQRT2_Q30 = 32'd759250125;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic [LOG_BITS-1:0] lg;
        logic                pos;
        logic                scale_en;
        logic [DATA_BITS-1:0] mul;
        logic [5:0]          shift;
    } r2fft_job_t;

    function automatic logic signed [DATA_BITS-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi)
            return 32'sh7fffffff;
        else if (v < lo)
            return 32'sh80000000;
        else
            return v[DATA_BITS-1:0];
    endfunction

    // Integer Taylor series in Q30, evaluated at elaboration or in the ROM only.
    function automatic void sincos_q30(input logic [63:0] t,
                                       output logic signed [63:0] s,
                                       output logic signed [63:0] c);
        logic [63:0] t2;
        logic [63:0] ts;
        logic [63:0] tc;
        t2 = (t * t) >> 30;
        ts = t;
        tc = 64'd1073741824;
        s = $signed(t);
        c = 64'sd1073741824;
        for (int n = 1; n <= 8; n++)
        begin
            ts = ((ts * t2) >> 30) / 64'((2 * n) * (2 * n + 1));
            tc = ((tc * t2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1)
            begin
                s = s - $signed(ts);
                c = c - $signed(tc);
            end
            else
            begin
                s = s + $signed(ts);
                c = c + $signed(tc);
            end
        end
    endfunction

    function automatic logic signed [31:0] quant_tw(input logic signed [63:0] v, input int tb);
        logic signed [63:0] r;
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        r = (v + (64'sd1 <<< (30 - tb))) >>> (31 - tb);
        hi = (64'sd1 <<< (tb - 1)) - 1;
        lo = -(64'sd1 <<< (tb - 1));
        if (r > hi)
            r = hi;
        if (r < lo)
            r = lo;
        return r[31:0];
    endfunction

    // Returns {cos, sin} for twiddle index k of a MaxPts-point table.
    function automatic logic [63:0] twiddle(input int k, input int MaxPts, input int tb);
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] t;
        logic signed [63:0] s;
        logic signed [63:0] c;
        logic signed [63:0] x;
        q = 64'((4 * k) / MaxPts);
        r = 64'(4 * k) - q * 64'(MaxPts);
        t = (64'd1686629713 * r + 64'(MaxPts / 2)) / 64'(MaxPts);
        sincos_q30(t, s, c);
        if (q != 0)
        begin
            x = s;
            s = c;
            c = -x;
        end
        return {quant_tw(c, tb), quant_tw(s, tb)};
    endfunction

endpackage

[src/r2fft_twiddle_rom.sv]
// Registered twiddle ROM: cosine and sine of one half-turn-spanning table.
`timescale 1ns / 1ps
module r2fft_twiddle_rom #(
    parameter int MAX_POINTS   = 1024,
    parameter int TWIDDLE_BITS = 18,
    parameter int ADDR_BITS    = 9
) (
    input  logic                           clk,
    input  logic [ADDR_BITS-1:0]           addr,
    output logic signed [TWIDDLE_BITS-1:0] cos_val,
    output logic signed [TWIDDLE_BITS-1:0] sin_val
);
    import r2fft_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [2*TWIDDLE_BITS-1:0] rom [DEPTH];

    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            logic [63:0] w;
            w = twiddle(k, MAX_POINTS, TWIDDLE_BITS);
            rom[k] = {w[32 +: TWIDDLE_BITS], w[0 +: TWIDDLE_BITS]};
        end
    end

    always_ff @(posedge clk)
    begin
        cos_val <= rom[addr][TWIDDLE_BITS +: TWIDDLE_BITS];
        sin_val <= rom[addr][0 +: TWIDDLE_BITS];
    end

endmodule

[src/r2fft_butterfly.sv]
// Pipelined butterfly / scaling datapath: multiply, round, add and saturate.
`timescale 1ns / 1ps
module r2fft_butterfly #(
    parameter int TWIDDLE_BITS = 18
) (
    input  logic                                 clk,
    input  logic                                 scale_mode,
    input  logic signed [r2fft_pkg::DATA_BITS-1:0] a_re,
    input  logic signed [r2fft_pkg::DATA_BITS-1:0] a_im,
    input  logic signed [r2fft_pkg::DATA_BITS-1:0] b_re,
    input  logic signed [r2fft_pkg::DATA_BITS-1:0] b_im,
    input  logic signed [TWIDDLE_BITS-1:0]       w_re,
    input  logic signed [TWIDDLE_BITS-1:0]       w_im,
    input  logic [r2fft_pkg::DATA_BITS-1:0]      mul,
    input  logic [5:0]                           shift,
    output logic signed [r2fft_pkg::DATA_BITS-1:0] x_re,
    output logic signed [r2fft_pkg::DATA_BITS-1:0] x_im,
    output logic signed [r2fft_pkg::DATA_BITS-1:0] y_re,
    output logic signed [r2fft_pkg::DATA_BITS-1:0] y_im
);
    import r2fft_pkg::*;

    localparam int PB = DATA_BITS + TWIDDLE_BITS;

    // stage 1: four products (or two scale products)
    logic signed [PB-1:0]   p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [63:0]     s_re_reg, s_im_reg;
    logic signed [DATA_BITS-1:0] a1_re_reg, a1_im_reg;
    logic [5:0]             sh1_reg;
    logic                   sm1_reg;
    // stage 2: rounded product
    logic signed [63:0]     m_re_reg, m_im_reg;
    logic signed [DATA_BITS-1:0] a2_re_reg, a2_im_reg;
    logic                   sm2_reg;

    logic signed [63:0] m_re_next, m_im_next, half;

    always_ff @(posedge clk)
    begin
        p_rr_reg  <= PB'(w_re * b_re);
        p_ii_reg  <= PB'(w_im * b_im);
        p_ri_reg  <= PB'(w_re * b_im);
        p_ir_reg  <= PB'(w_im * b_re);
        s_re_reg  <= 64'(a_re) * $signed({32'd0, mul});
        s_im_reg  <= 64'(a_im) * $signed({32'd0, mul});
        a1_re_reg <= a_re;
        a1_im_reg <= a_im;
        sh1_reg   <= shift;
        sm1_reg   <= scale_mode;
    end

    always_comb
    begin
        half = 64'sd1 <<< (sh1_reg - 6'd1);
        if (sm1_reg)
        begin
            m_re_next = (s_re_reg + half) >>> sh1_reg;
            m_im_next = (s_im_reg + half) >>> sh1_reg;
        end
        else
        begin
            m_re_next = (64'(p_rr_reg) - 64'(p_ii_reg) + (64'sd1 <<< (TWIDDLE_BITS - 2)))
                        >>> (TWIDDLE_BITS - 1);
            m_im_next = (64'(p_ri_reg) + 64'(p_ir_reg) + (64'sd1 <<< (TWIDDLE_BITS - 2)))
                        >>> (TWIDDLE_BITS - 1);
        end
    end

    always_ff @(posedge clk)
    begin
        m_re_reg  <= m_re_next;
        m_im_reg  <= m_im_next;
        a2_re_reg <= a1_re_reg;
        a2_im_reg <= a1_im_reg;
        sm2_reg   <= sm1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (sm2_reg)
        begin
            x_re <= sat32(m_re_reg);
            x_im <= sat32(m_im_reg);
        end
        else
        begin
            x_re <= sat32(64'(a2_re_reg) + m_re_reg);
            x_im <= sat32(64'(a2_im_reg) + m_im_reg);
        end
        y_re <= sat32(64'(a2_re_reg) - m_re_reg);
        y_im <= sat32(64'(a2_im_reg) - m_im_reg);
    end

endmodule

[src/radix2_complex_fft.sv]
// Top level of the radix-2 decimation-in-time FFT with its sample memory and sequencer.
`timescale 1ns / 1ps
// A load item (op 0) is written to memory on acceptance; the load that fills the frame
// starts the transform, during which s_tready is low. Bit reversal reads each index
// and, for each swapped pair, waits, then writes twice through the single write
// port. Each of the (N/2)*log2N butterflies reads both entries, waits on the twiddle
// ROM and the three-stage datapath, and then makes two writes. When scaling applies,
// each entry is read, waited on and written back. A read item (op 1) holds the input
// through accept, memory read and output register; a held bin does not block the
// input, but a second read waits in the output stage until the held bin is taken.
// A read with no finished frame is dropped with no result. The sample memory holds
// 64-bit complex entries and is not cleared.
module radix2_complex_fft #(
    parameter int MAX_POINTS   = r2fft_pkg::MAX_POINTS_DEF,
    parameter int SAMPLE_BITS  = r2fft_pkg::SAMPLE_BITS_DEF,
    parameter int TWIDDLE_BITS = r2fft_pkg::TWIDDLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [r2fft_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [r2fft_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [2*SAMPLE_BITS-1:0]              s_tdata,  // sample_re, sample_im
    input  logic                                  s_tuser,  // op
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [2*r2fft_pkg::DATA_BITS+15:0]    m_tdata,  // bin_re, bin_im, bin_index
    output logic                                  m_tlast   // last_bin
);
    import r2fft_pkg::*;

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int TWA  = (AW > 1) ? AW - 1 : 1;
    localparam int IDXW = 16;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_BR_RD = 4'd1;
    localparam logic [3:0] ST_BR_WAIT = 4'd2;
    localparam logic [3:0] ST_BR_WR = 4'd3;
    localparam logic [3:0] ST_BF_RD = 4'd4;
    localparam logic [3:0] ST_BF_WAIT = 4'd5;
    localparam logic [3:0] ST_BF_WR0 = 4'd6;
    localparam logic [3:0] ST_BF_WR1 = 4'd7;
    localparam logic [3:0] ST_SC_RD = 4'd8;
    localparam logic [3:0] ST_SC_WAIT = 4'd9;
    localparam logic [3:0] ST_SC_WR = 4'd10;
    localparam logic [3:0] ST_RD_WAIT = 4'd11;
    localparam logic [3:0] ST_RD_OUT = 4'd12;

    // configuration
    logic [3:0] lg_cfg_reg;
    logic       inv_reg, swap_reg;
    logic [1:0] smode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lg_cfg_reg <= 4'd10;
            inv_reg    <= 1'b0;
            swap_reg   <= 1'b0;
            smode_reg  <= SCALE_SQRT;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LOG2_POINTS: lg_cfg_reg <= cfg_data;
                REG_INVERSE:     inv_reg    <= cfg_data[0];
                REG_SWAP_SIGN:   swap_reg   <= cfg_data[0];
                REG_SCALING:     smode_reg  <= cfg_data[1:0];
                default:         ;
            endcase
        end
    end

    // effective length
    logic [LOG_BITS-1:0] lg_eff;
    always_comb
    begin
        if (lg_cfg_reg == 4'd0)
            lg_eff = LOG_BITS'(1);
        else if (LOG_BITS'(lg_cfg_reg) > LOG_BITS'(AW))
            lg_eff = LOG_BITS'(AW);
        else
            lg_eff = LOG_BITS'(lg_cfg_reg);
    end

    // memory
    logic [2*DATA_BITS-1:0] mem [MAX_POINTS];
    logic [AW-1:0]          ra0, ra1, wa;
    logic [2*DATA_BITS-1:0] rd0_reg, rd1_reg, wd;
    logic                   we;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd0_reg <= mem[ra0];
        rd1_reg <= mem[ra1];
    end

    // control state
    logic [3:0]        st_reg;
    logic [10:0]       load_cnt_reg, read_cnt_reg;
    logic              ready_reg;
    logic [LOG_BITS-1:0] flog_reg;
    r2fft_job_t        job_reg;
    logic [IDXW-1:0]   i_reg, j_reg, len_reg;   // loop counters
    logic [IDXW-1:0]   stride_reg;              // twiddle step, MAX_POINTS / (2*len)
    logic [3:0]        wait_reg;
    logic [AW-1:0]     rev_reg;
    logic              m_valid_reg, m_last_reg;
    logic [DATA_BITS-1:0] o_re_reg, o_im_reg;
    logic [9:0]        o_idx_reg;

    logic [IDXW-1:0] n_frame;
    assign n_frame = IDXW'(1) << job_reg.lg;

    // bit reverse of i within lg bits: reverse all AW bits, then drop the unused low end
    logic [AW-1:0] rev_full, rev_i;
    always_comb
    begin
        for (int b = 0; b < AW; b++)
            rev_full[AW-1-b] = i_reg[b];
        rev_i = rev_full >> (LOG_BITS'(AW) - job_reg.lg);
    end

    // twiddle address
    logic [TWA-1:0] tw_addr;
    logic [2*IDXW-1:0] tw_prod;
    assign tw_prod = (2*IDXW)'(j_reg) * (2*IDXW)'(stride_reg);
    assign tw_addr = tw_prod[TWA-1:0];

    logic signed [TWIDDLE_BITS-1:0] tw_cos, tw_sin, w_im;
    r2fft_twiddle_rom #(.MAX_POINTS(MAX_POINTS), .TWIDDLE_BITS(TWIDDLE_BITS),
                        .ADDR_BITS(TWA)) u_rom (
        .clk(clk), .addr(tw_addr), .cos_val(tw_cos), .sin_val(tw_sin));
    assign w_im = job_reg.pos ? tw_sin : -tw_sin;

    logic signed [DATA_BITS-1:0] x_re, x_im, y_re, y_im;
    logic sc_phase;
    assign sc_phase = (st_reg == ST_SC_WAIT) || (st_reg == ST_SC_WR);
    r2fft_butterfly #(.TWIDDLE_BITS(TWIDDLE_BITS)) u_bf (
        .clk(clk), .scale_mode(sc_phase),
        .a_re(rd0_reg[DATA_BITS +: DATA_BITS]), .a_im(rd0_reg[0 +: DATA_BITS]),
        .b_re(rd1_reg[DATA_BITS +: DATA_BITS]), .b_im(rd1_reg[0 +: DATA_BITS]),
        .w_re(tw_cos), .w_im(w_im), .mul(job_reg.mul), .shift(job_reg.shift),
        .x_re(x_re), .x_im(x_im), .y_re(y_re), .y_im(y_im));

    logic s_acc;
    assign s_tready = (st_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // a read is in its output state and the output register is free, or its bin leaves this cycle
    logic out_take;
    assign out_take = (st_reg == ST_RD_OUT) && (!m_valid_reg || m_tready);

    logic signed [SAMPLE_BITS-1:0] smp_re, smp_im;
    assign smp_re = s_tdata[0 +: SAMPLE_BITS];
    assign smp_im = s_tdata[SAMPLE_BITS +: SAMPLE_BITS];

    // memory port steering
    always_comb
    begin
        ra0 = i_reg[AW-1:0];
        ra1 = rev_reg;
        we  = 1'b0;
        wa  = i_reg[AW-1:0];
        wd  = rd1_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                ra0 = read_cnt_reg[AW-1:0];
                we  = s_acc && (s_tuser == OP_LOAD);
                wa  = load_cnt_reg[AW-1:0];
                wd  = {DATA_BITS'(smp_re), DATA_BITS'(smp_im)};
            end
            ST_RD_WAIT, ST_RD_OUT:
                ra0 = read_cnt_reg[AW-1:0];
            ST_BR_RD:
                ra1 = rev_i;
            ST_BR_WR:
            begin
                we = (wait_reg == 4'd0) || (wait_reg == 4'd1);
                wa = (wait_reg == 4'd0) ? i_reg[AW-1:0] : rev_reg;
                wd = (wait_reg == 4'd0) ? rd1_reg : rd0_reg;
            end
            ST_BF_RD, ST_BF_WAIT:
            begin
                ra0 = i_reg[AW-1:0];
                ra1 = AW'(i_reg + len_reg);
            end
            ST_BF_WR0:
            begin
                we = 1'b1;
                wa = i_reg[AW-1:0];
                wd = {x_re, x_im};
            end
            ST_BF_WR1:
            begin
                we = 1'b1;
                wa = AW'(i_reg + len_reg);
                wd = {y_re, y_im};
            end
            ST_SC_WR:
            begin
                we = 1'b1;
                wa = i_reg[AW-1:0];
                wd = {x_re, x_im};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_IDLE;
            load_cnt_reg <= '0;
            read_cnt_reg <= '0;
            ready_reg    <= 1'b0;
            flog_reg     <= LOG_BITS'(1);
            job_reg      <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            len_reg      <= '0;
            stride_reg   <= '0;
            wait_reg     <= '0;
            rev_reg      <= '0;
            m_valid_reg  <= 1'b0;
            m_last_reg   <= 1'b0;
            o_re_reg     <= '0;
            o_im_reg     <= '0;
            o_idx_reg    <= '0;
        end
        else
        begin
            if (out_take)
                m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_tready)
                m_valid_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (s_acc && s_tuser == OP_LOAD)
                    begin
                        ready_reg    <= 1'b0;
                        read_cnt_reg <= '0;
                        if ((load_cnt_reg + 11'd1) >= (11'd1 << lg_eff))
                        begin
                            load_cnt_reg <= '0;
                            job_reg.lg   <= lg_eff;
                            job_reg.pos  <= inv_reg ^ swap_reg;
                            job_reg.scale_en <= (smode_reg == SCALE_SQRT) ||
                                                (smode_reg == SCALE_ASYM && inv_reg);
                            job_reg.mul  <= (smode_reg == SCALE_SQRT && lg_eff[0])
                                            ? INV_SQRT2_Q30 : ONE_Q30;
                            job_reg.shift <= (smode_reg == SCALE_SQRT)
                                             ? 6'(30 + (lg_eff >> 1)) : 6'(30 + lg_eff);
                            i_reg        <= '0;
                            st_reg       <= ST_BR_RD;
                        end
                        else
                            load_cnt_reg <= load_cnt_reg + 11'd1;
                    end
                    else if (s_acc && ready_reg)
                        st_reg <= ST_RD_WAIT;
                end
                ST_BR_RD:
                begin
                    rev_reg  <= rev_i;
                    wait_reg <= 4'd0;
                    if (AW'(i_reg) < rev_i)
                        st_reg <= ST_BR_WAIT;
                    else if ((i_reg + IDXW'(1)) >= n_frame)
                    begin
                        i_reg <= '0; j_reg <= '0; len_reg <= IDXW'(1);
                        stride_reg <= IDXW'(MAX_POINTS / 2);
                        st_reg <= ST_BF_RD;
                    end
                    else
                        i_reg <= i_reg + IDXW'(1);
                end
                ST_BR_WAIT:
                    st_reg <= ST_BR_WR;
                ST_BR_WR:
                begin
                    if (wait_reg == 4'd1)
                    begin
                        if ((i_reg + IDXW'(1)) >= n_frame)
                        begin
                            i_reg <= '0; j_reg <= '0; len_reg <= IDXW'(1);
                            stride_reg <= IDXW'(MAX_POINTS / 2);
                            st_reg <= ST_BF_RD;
                        end
                        else
                        begin
                            i_reg  <= i_reg + IDXW'(1);
                            st_reg <= ST_BR_RD;
                        end
                    end
                    wait_reg <= wait_reg + 4'd1;
                end
                ST_BF_RD:
                begin
                    wait_reg <= 4'd0;
                    st_reg   <= ST_BF_WAIT;
                end
                ST_BF_WAIT:
                begin
                    wait_reg <= wait_reg + 4'd1;
                    if (wait_reg == 4'd3)
                        st_reg <= ST_BF_WR0;
                end
                ST_BF_WR0:
                    st_reg <= ST_BF_WR1;
                ST_BF_WR1:
                begin
                    st_reg <= ST_BF_RD;
                    if ((i_reg + len_reg + (len_reg << 1)) < n_frame)
                        i_reg <= i_reg + (len_reg << 1);
                    else if ((j_reg + IDXW'(1)) < len_reg)
                    begin
                        j_reg <= j_reg + IDXW'(1);
                        i_reg <= j_reg + IDXW'(1);
                    end
                    else if ((len_reg << 1) < n_frame)
                    begin
                        len_reg    <= len_reg << 1;
                        stride_reg <= stride_reg >> 1;
                        j_reg      <= '0;
                        i_reg      <= '0;
                    end
                    else
                    begin
                        i_reg <= '0;
                        if (job_reg.scale_en)
                            st_reg <= ST_SC_RD;
                        else
                        begin
                            flog_reg  <= job_reg.lg;
                            ready_reg <= 1'b1;
                            st_reg    <= ST_IDLE;
                        end
                    end
                end
                ST_SC_RD:
                begin
                    wait_reg <= 4'd0;
                    st_reg   <= ST_SC_WAIT;
                end
                ST_SC_WAIT:
                begin
                    wait_reg <= wait_reg + 4'd1;
                    if (wait_reg == 4'd3)
                        st_reg <= ST_SC_WR;
                end
                ST_SC_WR:
                begin
                    if ((i_reg + IDXW'(1)) >= n_frame)
                    begin
                        flog_reg  <= job_reg.lg;
                        ready_reg <= 1'b1;
                        st_reg    <= ST_IDLE;
                    end
                    else
                    begin
                        i_reg  <= i_reg + IDXW'(1);
                        st_reg <= ST_SC_RD;
                    end
                end
                ST_RD_WAIT:
                    st_reg <= ST_RD_OUT;
                ST_RD_OUT:
                begin
                    // waits here while the previous bin is still held
                    if (out_take)
                    begin
                        o_re_reg    <= rd0_reg[DATA_BITS +: DATA_BITS];
                        o_im_reg    <= rd0_reg[0 +: DATA_BITS];
                        o_idx_reg   <= 10'(read_cnt_reg);
                        m_last_reg  <= (read_cnt_reg + 11'd1) >= (11'd1 << flog_reg);
                        if ((read_cnt_reg + 11'd1) >= (11'd1 << flog_reg))
                        begin
                            read_cnt_reg <= '0;
                            ready_reg    <= 1'b0;
                        end
                        else
                            read_cnt_reg <= read_cnt_reg + 11'd1;
                        st_reg <= ST_IDLE;
                    end
                end
                default:
                    st_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {6'd0, o_idx_reg, o_im_reg, o_re_reg};

endmodule

[tb/fft_checker.sv]
// Checker for the radix-2 FFT: tracks channel traffic, predicts bins and compares them.
`timescale 1ns / 1ps
module fft_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic        m_tlast,
    output int          errors,
    output int          pending,
    output int          bins_seen,
    output int          frames_done
);
    import r2fft_pkg::*;

    localparam int NPTS = 1024;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [9:0]         idx;
        logic               last;
    } bin_t;

    bin_t bin_queue[$];

    int  mem_re[NPTS];
    int  mem_im[NPTS];
    int  rom_cos[NPTS/2];
    int  rom_sin[NPTS/2];
    int  load_cnt;
    int  read_cnt;
    bit  have_frame;
    int  frame_lg;
    logic [3:0] lg_reg;
    logic       inv_reg;
    logic       swap_reg;
    logic [1:0] scale_reg;

    function automatic int clip32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return int'(v);
    endfunction

    // Integer Taylor series, Q30 in and out.
    function automatic void taylor_sc(input bit [63:0] t, output longint s, output longint c);
        bit [63:0] t2;
        bit [63:0] ts;
        bit [63:0] tc;
        t2 = (t * t) >> 30;
        ts = t;
        tc = 64'd1 << 30;
        s = longint'(t);
        c = longint'(64'd1 << 30);
        for (int n = 1; n <= 8; n++)
        begin
            ts = ((ts * t2) >> 30) / 64'((2 * n) * (2 * n + 1));
            tc = ((tc * t2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1)
            begin
                s = s - longint'(ts);
                c = c - longint'(tc);
            end
            else
            begin
                s = s + longint'(ts);
                c = c + longint'(tc);
            end
        end
    endfunction

    function automatic int to_q17(longint v);
        longint r;
        r = (v + 64'sd4096) >>> 13;
        if (r > 64'sd131071)
            r = 131071;
        if (r < -64'sd131072)
            r = -131072;
        return int'(r);
    endfunction

    initial
    begin
        bit [63:0] q;
        bit [63:0] r;
        bit [63:0] t;
        longint s;
        longint c;
        longint x;
        for (int k = 0; k < NPTS / 2; k++)
        begin
            q = 64'((4 * k) / NPTS);
            r = 64'(4 * k) - q * 64'(NPTS);
            t = (64'd1686629713 * r + 64'(NPTS / 2)) / 64'(NPTS);
            taylor_sc(t, s, c);
            if (q != 0)
            begin
                x = s;
                s = c;
                c = -x;
            end
            rom_cos[k] = to_q17(c);
            rom_sin[k] = to_q17(s);
        end
    end

    function automatic void scale_frame(int n, longint mul, int sh);
        longint half;
        half = 64'sd1 <<< (sh - 1);
        for (int i = 0; i < n; i++)
        begin
            mem_re[i] = clip32((longint'(mem_re[i]) * mul + half) >>> sh);
            mem_im[i] = clip32((longint'(mem_im[i]) * mul + half) >>> sh);
        end
    endfunction

    function automatic void run_fft(int lg);
        int n;
        int rv;
        int tmp;
        int stride;
        int k;
        bit pos;
        longint wr;
        longint wi;
        longint ar;
        longint ai;
        longint br;
        longint bi;
        longint mr;
        longint mi;
        n = 1 << lg;
        pos = inv_reg ^ swap_reg;
        for (int i = 0; i < n; i++)
        begin
            rv = 0;
            for (int b = 0; b < lg; b++)
                if (i & (1 << b))
                    rv |= 1 << (lg - 1 - b);
            if (i < rv)
            begin
                tmp = mem_re[i]; mem_re[i] = mem_re[rv]; mem_re[rv] = tmp;
                tmp = mem_im[i]; mem_im[i] = mem_im[rv]; mem_im[rv] = tmp;
            end
        end
        for (int len = 1; len < n; len <<= 1)
        begin
            stride = NPTS / (2 * len);
            for (int j = 0; j < len; j++)
            begin
                k = (j * stride) % (NPTS / 2);
                wr = rom_cos[k];
                wi = pos ? longint'(rom_sin[k]) : -longint'(rom_sin[k]);
                for (int i = j; i + len < n; i += 2 * len)
                begin
                    ar = mem_re[i];
                    ai = mem_im[i];
                    br = mem_re[i + len];
                    bi = mem_im[i + len];
                    mr = (wr * br - wi * bi + 64'sd65536) >>> 17;
                    mi = (wr * bi + wi * br + 64'sd65536) >>> 17;
                    mem_re[i]       = clip32(ar + mr);
                    mem_im[i]       = clip32(ai + mi);
                    mem_re[i + len] = clip32(ar - mr);
                    mem_im[i + len] = clip32(ai - mi);
                end
            end
        end
        if (scale_reg == SCALE_SQRT)
            scale_frame(n, lg[0] ? longint'(INV_SQRT2_Q30) : longint'(ONE_Q30), 30 + lg / 2);
        else if (scale_reg == SCALE_ASYM && inv_reg)
            scale_frame(n, longint'(ONE_Q30), 30 + lg);
    endfunction

    function automatic void take_item(logic op, logic signed [15:0] re, logic signed [15:0] im);
        int lg;
        int idx;
        bin_t b;
        if (op == OP_LOAD)
        begin
            lg = (lg_reg < 1) ? 1 : (lg_reg > 10) ? 10 : int'(lg_reg);
            idx = load_cnt & (NPTS - 1);
            have_frame = 0;
            read_cnt = 0;
            mem_re[idx] = re;
            mem_im[idx] = im;
            load_cnt = (load_cnt + 1) & 11'h7ff;
            if (load_cnt >= (1 << lg))
            begin
                run_fft(lg);
                frame_lg = lg;
                have_frame = 1;
                load_cnt = 0;
                frames_done++;
            end
        end
        else if (have_frame)
        begin
            idx = read_cnt & (NPTS - 1);
            b.re = mem_re[idx];
            b.im = mem_im[idx];
            b.idx = idx[9:0];
            b.last = (read_cnt + 1 >= (1 << frame_lg));
            bin_queue.push_back(b);
            read_cnt++;
            if (read_cnt >= (1 << frame_lg))
            begin
                read_cnt = 0;
                have_frame = 0;
            end
        end
    endfunction

    assign pending = bin_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        bin_t b;
        if (!rst_n)
        begin
            bin_queue.delete();
            load_cnt = 0;
            read_cnt = 0;
            have_frame = 0;
            frame_lg = 1;
            lg_reg = 4'd10;
            inv_reg = 0;
            swap_reg = 0;
            scale_reg = SCALE_SQRT;
            errors = 0;
            bins_seen = 0;
            frames_done = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                bins_seen++;
                if (bin_queue.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected bin: %h last %b", m_tdata, m_tlast);
                end
                else
                begin
                    b = bin_queue.pop_front();
                    if (m_tdata[31:0] !== b.re || m_tdata[63:32] !== b.im
                        || m_tdata[73:64] !== b.idx || m_tlast !== b.last)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("bin mismatch: exp re %0d im %0d idx %0d last %b, got re %0d im %0d idx %0d last %b",
                                     b.re, b.im, b.idx, b.last, $signed(m_tdata[31:0]),
                                     $signed(m_tdata[63:32]), m_tdata[73:64], m_tlast);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LOG2_POINTS: lg_reg = cfg_data;
                    REG_INVERSE:     inv_reg = cfg_data[0];
                    REG_SWAP_SIGN:   swap_reg = cfg_data[0];
                    REG_SCALING:     scale_reg = cfg_data[1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                take_item(s_tuser, s_tdata[15:0], s_tdata[31:16]);
        end
    end

endmodule

[tb/testbench.sv]
// Top of the radix-2 FFT testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import r2fft_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [3:0]  cfg_data = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // sample_re, sample_im
    logic        s_tuser = 0;    // op
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [79:0] m_tdata;        // bin_re, bin_im, bin_index
    logic        m_tlast;        // last_bin

    int errors;
    int pending;
    int bins_seen;
    int frames_done;
    int items_sent = 0;
    int burst_left = 0;
    bit hold_req = 0;

    radix2_complex_fft dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    fft_checker chk (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .errors(errors), .pending(pending), .bins_seen(bins_seen), .frames_done(frames_done)
    );

    initial
    begin
        forever
            #4 clk = ~clk;
    end

    initial
    begin
        #10000000;
        $display("[radix2_complex_fft] ERROR");
        $finish;
    end

    // Receiver: stall pattern changes at random; long hold-off on request.
    initial
    begin
        int mode;
        int hold;
        mode = 0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                m_tready <= 0;
            end
            else if (hold_req)
            begin
                hold_req = 0;
                hold = 400;
                m_tready <= 0;
            end
            else
            begin
                if ($urandom_range(0, 63) == 0)
                    mode = $urandom_range(0, 2);
                case (mode)
                    0: m_tready <= 1;
                    1: m_tready <= $urandom_range(0, 1);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic set_config(int lg, int inv, int swp, int scl);
        write_reg(REG_LOG2_POINTS, 4'(lg));
        write_reg(REG_INVERSE, 4'(inv));
        write_reg(REG_SWAP_SIGN, 4'(swp));
        write_reg(REG_SCALING, 4'(scl));
    endtask

    task automatic send(logic op, logic [15:0] re, logic [15:0] im, bit counted);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 0;
                repeat (gap)
                    @(posedge clk);
            end
        end
        burst_left--;
        s_tuser <= op;
        s_tdata <= {im, re};
        s_tvalid <= 1;
        do
            @(posedge clk);
        while (!s_tready);
        if (counted)
            items_sent++;
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 63)) - 16'd32;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_frame(int n);
        for (int i = 0; i < n; i++)
            send(OP_LOAD, pick_sample(), pick_sample(), 1);
    endtask

    task automatic read_bins(int n);
        for (int i = 0; i < n; i++)
            send(OP_READ, 16'($urandom), 16'($urandom), 1);
    endtask

    // Lower valid and let every expected bin drain before touching registers.
    task automatic settle();
        s_tvalid <= 0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
    endtask

    initial
    begin
        int lg;
        int n;
        repeat (11)
            @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: two-point frames, full-scale samples, abandon and odd cases
        set_config(1, 0, 0, SCALE_SQRT);
        send(OP_READ, 16'h0, 16'h0, 0);          // read with no frame is dropped
        send(OP_LOAD, 16'h7fff, 16'h7fff, 1);
        send(OP_LOAD, 16'h8000, 16'h8000, 1);
        read_bins(2);
        send(OP_READ, 16'hffff, 16'hffff, 0);
        send(OP_LOAD, 16'h8000, 16'h7fff, 1);
        send(OP_LOAD, 16'h7fff, 16'h8000, 1);
        read_bins(1);
        send(OP_LOAD, 16'h0001, 16'hffff, 1);   // abandons the unread bin
        send(OP_LOAD, 16'h0000, 16'h0000, 1);
        read_bins(2);
        settle();
        // length shrunk mid-load; log2 of zero acts as one
        write_reg(REG_LOG2_POINTS, 4'd2);
        send(OP_LOAD, 16'd100, -16'sd7, 1);
        settle();
        write_reg(REG_LOG2_POINTS, 4'd0);
        send(OP_LOAD, 16'h5555, 16'haaaa, 1);
        read_bins(2);
        settle();
        set_config(1, 1, 1, SCALE_ASYM);
        load_frame(2);
        read_bins(2);
        settle();
        set_config(2, 1, 0, 3);
        load_frame(4);
        read_bins(4);
        settle();

        // largest frame, oversized log2 clamps; receiver holds off mid-readout
        set_config(15, 0, 0, SCALE_ASYM);
        load_frame(1024);
        hold_req = 1;
        read_bins(160);
        settle();

        while (items_sent < 1450)
        begin
            lg = ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, 6);
            set_config(lg, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 3));
            n = 1 << ((lg < 1) ? 1 : lg);
            if ($urandom_range(0, 3) == 0)
                send(OP_READ, 16'($urandom), 16'($urandom), 0);
            load_frame(n);
            if ($urandom_range(0, 5) == 0)
            begin
                read_bins($urandom_range(1, n));
                load_frame(n);
            end
            read_bins(n);
            if ($urandom_range(0, 3) == 0)
                send(OP_READ, 16'($urandom), 16'($urandom), 0);
            settle();
        end

        repeat (100)
            @(posedge clk);
        $display("covered %0d items, %0d transforms, %0d bins checked", items_sent,
                 frames_done, bins_seen);
        $display("lengths 2..1024, both directions, sign swap, all scaling modes, stalls");
        if (errors == 0)
            $display("[radix2_complex_fft] OK");
        else
            $display("[radix2_complex_fft] ERROR");
        $finish;
    end

endmodule
